// ===== rtl/dd_pkg.sv =====
// ----------------------------------------------------------------------------
// Drawdown tracker package
// Shared widths, default parameter values and status codes.
// ----------------------------------------------------------------------------
package dd_pkg;

    localparam int DEF_FRACTION_BITS = 24;
    localparam int DEF_EQUITY_BITS   = 48;
    localparam int DEF_TIME_BITS     = 62;
    localparam int DEF_COUNT_BITS    = 32;

    // Fixed widths of the result fields.
    localparam int DD_BITS      = 32;
    localparam int CNT_OUT_BITS = 32;
    localparam int STATUS_BITS  = 2;

    typedef logic [STATUS_BITS-1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_TIME  = 2'd1;
    localparam t_status ST_BACKWARD = 2'd2;

endpackage

// ===== rtl/dd_if.sv =====
// ----------------------------------------------------------------------------
// Drawdown tracker channels
// Sample request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dd_in_if
    import dd_pkg::*;
#(
    parameter int TIME_BITS   = DEF_TIME_BITS,
    parameter int EQUITY_BITS = DEF_EQUITY_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          time_present;
    logic [TIME_BITS-1:0]          event_time;
    logic signed [EQUITY_BITS-1:0] equity;

    modport source (output valid, time_present, event_time, equity, input ready);
    modport sink   (input valid, time_present, event_time, equity, output ready);
endinterface

interface dd_out_if
    import dd_pkg::*;
#(
    parameter int TIME_BITS   = DEF_TIME_BITS,
    parameter int EQUITY_BITS = DEF_EQUITY_BITS
);
    logic                          valid;
    logic                          ready;
    t_status                       status;
    logic [DD_BITS-1:0]            drawdown;
    logic signed [EQUITY_BITS-1:0] peak_level;
    logic [CNT_OUT_BITS-1:0]       underwater_count;
    logic [DD_BITS-1:0]            max_drawdown;
    logic [TIME_BITS-1:0]          max_peak_time;
    logic [TIME_BITS-1:0]          max_trough_time;
    logic [CNT_OUT_BITS-1:0]       longest_underwater;
    logic                          episode_closed;
    logic [TIME_BITS-1:0]          episode_peak_time;
    logic [TIME_BITS-1:0]          episode_trough_time;
    logic [DD_BITS-1:0]            episode_depth;

    modport source (
        output valid, status, drawdown, peak_level, underwater_count, max_drawdown,
               max_peak_time, max_trough_time, longest_underwater, episode_closed,
               episode_peak_time, episode_trough_time, episode_depth,
        input  ready
    );
    modport sink (
        input  valid, status, drawdown, peak_level, underwater_count, max_drawdown,
               max_peak_time, max_trough_time, longest_underwater, episode_closed,
               episode_peak_time, episode_trough_time, episode_depth,
        output ready
    );
endinterface

// ===== rtl/dd_div.sv =====
// ----------------------------------------------------------------------------
// Drawdown divider
// Restoring radix-2 divider: floor(num * 2^FRACTION_BITS / den), saturated
// to the fixed-point result width. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module dd_div
    import dd_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int EQUITY_BITS   = DEF_EQUITY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [EQUITY_BITS-1:0] i_num,
    input  logic [EQUITY_BITS-1:0] i_den,
    output logic                   o_done,
    output logic [DD_BITS-1:0]     o_quot
);

    localparam int WIDE     = EQUITY_BITS + DD_BITS;
    localparam int SHIFT    = DD_BITS - FRACTION_BITS;
    localparam int CNT_BITS = $clog2(DD_BITS);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_RUN   = 2'd2;

    logic [1:0]             r_state;
    logic [EQUITY_BITS-1:0] r_num;
    logic [EQUITY_BITS-1:0] r_den;
    logic [EQUITY_BITS-1:0] r_rem;
    logic [DD_BITS-1:0]     r_low;
    logic [DD_BITS-1:0]     r_quot;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_done;

    logic [WIDE-1:0]        w_num_wide;
    logic [WIDE-1:0]        w_num_sh;
    logic [WIDE-1:0]        w_den_sh;
    logic                   w_sat;
    logic [EQUITY_BITS:0]   w_trial;
    logic [EQUITY_BITS:0]   w_diff;
    logic                   w_ge;

    assign w_num_wide = {{DD_BITS{1'b0}}, r_num};
    assign w_num_sh   = w_num_wide << FRACTION_BITS;
    assign w_den_sh   = {{DD_BITS{1'b0}}, r_den} << SHIFT;
    // The integer part reaching the unused high bits means saturation.
    assign w_sat      = w_num_wide >= w_den_sh;

    assign w_trial = {r_rem, r_low[DD_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    if (w_sat) begin
                        r_quot  <= '1;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        // Remainder starts below den, so every quotient bit fits.
                        r_rem   <= r_num >> SHIFT;
                        r_low   <= w_num_sh[DD_BITS-1:0];
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= w_ge ? w_diff[EQUITY_BITS-1:0] : w_trial[EQUITY_BITS-1:0];
                    r_low  <= {r_low[DD_BITS-2:0], 1'b0};
                    r_quot <= {r_quot[DD_BITS-2:0], w_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(DD_BITS - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/drawdown_tracker.sv =====
// ----------------------------------------------------------------------------
// Drawdown tracker
// Running peak, drawdown, underwater runs and drawdown episodes of a
// timestamped equity series, one result per sample.
// ----------------------------------------------------------------------------
//  Port    | Dir | Carries
//  --------+-----+---------------------------------------------------------
//  i_in    | in  | sample request: time_present, event_time, equity
//  o_out   | out | result: status, drawdowns, peak, counts, closed episode
//
// An underwater sample with a positive peak goes through the divider, which
// first checks for saturation and then, unless the check finds it, works out
// the quotient bit by bit. Every other sample skips the divider. The result
// sits in an output register, so the next sample is taken while it waits; a
// stalled result only holds back the following one. Reset is synchronous and
// clears all tracking state to zero.
module drawdown_tracker
    import dd_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int EQUITY_BITS   = DEF_EQUITY_BITS,
    parameter int TIME_BITS     = DEF_TIME_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dd_in_if.sink    i_in,
    dd_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;

    // Latched sample
    logic                          r_in_tp;
    logic [TIME_BITS-1:0]          r_in_time;
    logic signed [EQUITY_BITS-1:0] r_in_eq;
    logic [DD_BITS-1:0]            r_dd;

    // Tracking state
    logic                          r_last_known;
    logic [TIME_BITS-1:0]          r_last_time;
    logic                          r_peak_known;
    logic signed [EQUITY_BITS-1:0] r_peak;
    logic [TIME_BITS-1:0]          r_peak_time;
    logic [COUNT_BITS-1:0]         r_run;
    logic [COUNT_BITS-1:0]         r_longest;
    logic [DD_BITS-1:0]            r_worst;
    logic [TIME_BITS-1:0]          r_worst_peak_time;
    logic [TIME_BITS-1:0]          r_worst_trough_time;
    logic                          r_ep_open;
    logic [TIME_BITS-1:0]          r_ep_peak_time;
    logic [TIME_BITS-1:0]          r_ep_trough_time;
    logic signed [EQUITY_BITS-1:0] r_ep_trough_level;
    logic [DD_BITS-1:0]            r_ep_depth;

    logic                          n_last_known;
    logic [TIME_BITS-1:0]          n_last_time;
    logic                          n_peak_known;
    logic signed [EQUITY_BITS-1:0] n_peak;
    logic [TIME_BITS-1:0]          n_peak_time;
    logic [COUNT_BITS-1:0]         n_run;
    logic [COUNT_BITS-1:0]         n_longest;
    logic [DD_BITS-1:0]            n_worst;
    logic [TIME_BITS-1:0]          n_worst_peak_time;
    logic [TIME_BITS-1:0]          n_worst_trough_time;
    logic                          n_ep_open;
    logic [TIME_BITS-1:0]          n_ep_peak_time;
    logic [TIME_BITS-1:0]          n_ep_trough_time;
    logic signed [EQUITY_BITS-1:0] n_ep_trough_level;
    logic [DD_BITS-1:0]            n_ep_depth;

    // Output register
    logic                          r_out_valid;
    t_status                       r_o_status;
    logic [DD_BITS-1:0]            r_o_dd;
    logic                          r_o_closed;
    logic [TIME_BITS-1:0]          r_o_ep_peak_time;
    logic [TIME_BITS-1:0]          r_o_ep_trough_time;
    logic [DD_BITS-1:0]            r_o_ep_depth;
    logic signed [EQUITY_BITS-1:0] r_o_peak;
    logic [COUNT_BITS-1:0]         r_o_run;
    logic [COUNT_BITS-1:0]         r_o_longest;
    logic [DD_BITS-1:0]            r_o_worst;
    logic [TIME_BITS-1:0]          r_o_worst_peak_time;
    logic [TIME_BITS-1:0]          r_o_worst_trough_time;

    t_status                       n_status;
    logic                          n_closed;
    logic [TIME_BITS-1:0]          n_o_ep_peak_time;
    logic [TIME_BITS-1:0]          n_o_ep_trough_time;
    logic [DD_BITS-1:0]            n_o_ep_depth;
    logic [DD_BITS-1:0]            n_o_dd;

    logic                          w_new_peak;
    logic                          w_need_div;
    logic                          w_out_free;
    logic                          w_load;
    logic signed [EQUITY_BITS:0]   w_gap;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [DD_BITS-1:0]            w_div_quot;

    always_comb begin
        if (!r_in_tp) begin
            n_status = ST_NO_TIME;
        end else if (r_last_known && (r_in_time < r_last_time)) begin
            n_status = ST_BACKWARD;
        end else begin
            n_status = ST_OK;
        end
    end

    assign w_new_peak  = !r_peak_known || (r_in_eq >= r_peak);
    assign w_need_div  = (n_status == ST_OK) && !w_new_peak && (r_peak > 0);
    assign w_gap       = {r_peak[EQUITY_BITS-1], r_peak} - {r_in_eq[EQUITY_BITS-1], r_in_eq};
    assign w_div_start = (r_state == S_EVAL) && w_need_div;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_load      = (r_state == S_DONE) && w_out_free;

    dd_div #(
        .FRACTION_BITS (FRACTION_BITS),
        .EQUITY_BITS   (EQUITY_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_gap[EQUITY_BITS-1:0]),
        .i_den   (r_peak),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        n_last_known        = r_last_known;
        n_last_time         = r_last_time;
        n_peak_known        = r_peak_known;
        n_peak              = r_peak;
        n_peak_time         = r_peak_time;
        n_run               = r_run;
        n_longest           = r_longest;
        n_worst             = r_worst;
        n_worst_peak_time   = r_worst_peak_time;
        n_worst_trough_time = r_worst_trough_time;
        n_ep_open           = r_ep_open;
        n_ep_peak_time      = r_ep_peak_time;
        n_ep_trough_time    = r_ep_trough_time;
        n_ep_trough_level   = r_ep_trough_level;
        n_ep_depth          = r_ep_depth;
        n_closed            = 1'b0;
        n_o_ep_peak_time    = '0;
        n_o_ep_trough_time  = '0;
        n_o_ep_depth        = '0;
        n_o_dd              = '0;
        if (n_status == ST_OK) begin
            n_last_known = 1'b1;
            n_last_time  = r_in_time;
            if (w_new_peak) begin
                if (r_ep_open) begin
                    n_closed           = 1'b1;
                    n_o_ep_peak_time   = r_ep_peak_time;
                    n_o_ep_trough_time = r_ep_trough_time;
                    n_o_ep_depth       = r_ep_depth;
                    n_ep_open          = 1'b0;
                end
                n_peak       = r_in_eq;
                n_peak_time  = r_in_time;
                n_peak_known = 1'b1;
                n_run        = '0;
            end else begin
                n_o_dd = r_dd;
                if (r_run != '1) begin
                    n_run = r_run + 1'b1;
                end
                if (n_run > r_longest) begin
                    n_longest = n_run;
                end
                if (!r_ep_open || (r_in_eq < r_ep_trough_level)) begin
                    n_ep_open         = 1'b1;
                    n_ep_trough_time  = r_in_time;
                    n_ep_trough_level = r_in_eq;
                    n_ep_depth        = r_dd;
                end
                if (!r_ep_open) begin
                    n_ep_peak_time = r_peak_time;
                end
                if (r_dd > r_worst) begin
                    n_worst             = r_dd;
                    n_worst_peak_time   = r_peak_time;
                    n_worst_trough_time = r_in_time;
                end
            end
        end
    end

    // Sequencer and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_IDLE;
            r_last_known        <= 1'b0;
            r_last_time         <= '0;
            r_peak_known        <= 1'b0;
            r_peak              <= '0;
            r_peak_time         <= '0;
            r_run               <= '0;
            r_longest           <= '0;
            r_worst             <= '0;
            r_worst_peak_time   <= '0;
            r_worst_trough_time <= '0;
            r_ep_open           <= 1'b0;
            r_ep_peak_time      <= '0;
            r_ep_trough_time    <= '0;
            r_ep_trough_level   <= '0;
            r_ep_depth          <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= w_need_div ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state             <= S_IDLE;
                        r_last_known        <= n_last_known;
                        r_last_time         <= n_last_time;
                        r_peak_known        <= n_peak_known;
                        r_peak              <= n_peak;
                        r_peak_time         <= n_peak_time;
                        r_run               <= n_run;
                        r_longest           <= n_longest;
                        r_worst             <= n_worst;
                        r_worst_peak_time   <= n_worst_peak_time;
                        r_worst_trough_time <= n_worst_trough_time;
                        r_ep_open           <= n_ep_open;
                        r_ep_peak_time      <= n_ep_peak_time;
                        r_ep_trough_time    <= n_ep_trough_time;
                        r_ep_trough_level   <= n_ep_trough_level;
                        r_ep_depth          <= n_ep_depth;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sample capture and drawdown holding register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in.valid) begin
            r_in_tp   <= i_in.time_present;
            r_in_time <= i_in.event_time;
            r_in_eq   <= i_in.equity;
        end
        if (r_state == S_EVAL) begin
            r_dd <= '0;
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_dd <= w_div_quot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status            <= n_status;
            r_o_dd                <= n_o_dd;
            r_o_closed            <= n_closed;
            r_o_ep_peak_time      <= n_o_ep_peak_time;
            r_o_ep_trough_time    <= n_o_ep_trough_time;
            r_o_ep_depth          <= n_o_ep_depth;
            r_o_peak              <= n_peak;
            r_o_run               <= n_run;
            r_o_longest           <= n_longest;
            r_o_worst             <= n_worst;
            r_o_worst_peak_time   <= n_worst_peak_time;
            r_o_worst_trough_time <= n_worst_trough_time;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid               = r_out_valid;
    assign o_out.status              = r_o_status;
    assign o_out.drawdown            = r_o_dd;
    assign o_out.peak_level          = r_o_peak;
    assign o_out.underwater_count    = CNT_OUT_BITS'(r_o_run);
    assign o_out.max_drawdown        = r_o_worst;
    assign o_out.max_peak_time       = r_o_worst_peak_time;
    assign o_out.max_trough_time     = r_o_worst_trough_time;
    assign o_out.longest_underwater  = CNT_OUT_BITS'(r_o_longest);
    assign o_out.episode_closed      = r_o_closed;
    assign o_out.episode_peak_time   = r_o_ep_peak_time;
    assign o_out.episode_trough_time = r_o_ep_trough_time;
    assign o_out.episode_depth       = r_o_ep_depth;

endmodule

// ===== tb/drawdown_tracker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Drawdown tracker testbench
// Sends timestamped equity samples through the request channel and predicts
// every result with a behavioral model of the tracker, kept in a small
// scoreboard. Directed samples cover the corner cases. Random-walk sequences
// around the running peak follow, mixed with random noise and bad timestamps,
// under three idling profiles and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module drawdown_tracker_tb;
    import dd_pkg::*;

    localparam int TIME_W = DEF_TIME_BITS;
    localparam int EQ_W   = DEF_EQUITY_BITS;
    localparam int FRAC_W = DEF_FRACTION_BITS;
    localparam int CNT_W  = DEF_COUNT_BITS;

    localparam logic [EQ_W-1:0] EQ_TOP    = {1'b0, {(EQ_W-1){1'b1}}};
    localparam logic [EQ_W-1:0] EQ_BOTTOM = {1'b1, {(EQ_W-1){1'b0}}};
    localparam longint          EQ_HI     = (64'sd1 <<< (EQ_W - 1)) - 1;
    localparam longint          EQ_LO     = -EQ_HI - 1;
    localparam int              HOLD_CYCLES = 300;

    typedef struct packed {
        t_status                 status;
        logic [DD_BITS-1:0]      drawdown;
        logic [EQ_W-1:0]         peak_level;
        logic [CNT_OUT_BITS-1:0] underwater_count;
        logic [DD_BITS-1:0]      max_drawdown;
        logic [TIME_W-1:0]       max_peak_time;
        logic [TIME_W-1:0]       max_trough_time;
        logic [CNT_OUT_BITS-1:0] longest_underwater;
        logic                    episode_closed;
        logic [TIME_W-1:0]       episode_peak_time;
        logic [TIME_W-1:0]       episode_trough_time;
        logic [DD_BITS-1:0]      episode_depth;
    } t_dd_result;

    class drawdown_scoreboard;
        bit                      have_time;
        logic [TIME_W-1:0]       prev_time;
        bit                      have_peak;
        logic signed [EQ_W-1:0]  peak_eq;
        logic [TIME_W-1:0]       peak_at;
        logic [CNT_W-1:0]        run_len;
        logic [CNT_W-1:0]        longest_len;
        logic [DD_BITS-1:0]      worst_dd;
        logic [TIME_W-1:0]       worst_peak_at;
        logic [TIME_W-1:0]       worst_trough_at;
        bit                      in_episode;
        logic [TIME_W-1:0]       ep_peak_at;
        logic [TIME_W-1:0]       ep_trough_at;
        logic signed [EQ_W-1:0]  ep_trough_eq;
        logic [DD_BITS-1:0]      ep_depth_dd;
        t_dd_result              pending_results[$];
        int                      mismatches;
        int                      results_seen;

        function new();
            have_time = 0;
            prev_time = '0;
            have_peak = 0;
            peak_eq = '0;
            peak_at = '0;
            run_len = '0;
            longest_len = '0;
            worst_dd = '0;
            worst_peak_at = '0;
            worst_trough_at = '0;
            in_episode = 0;
            ep_peak_at = '0;
            ep_trough_at = '0;
            ep_trough_eq = '0;
            ep_depth_dd = '0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // Exact quotient of (peak - equity) / peak with FRAC_W fraction bits,
        // truncated, saturating to all ones when it does not fit.
        function logic [DD_BITS-1:0] fraction_below(logic signed [EQ_W-1:0] pk,
                                                    logic signed [EQ_W-1:0] eq);
            longint       gap;
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] quo;
            if (pk <= 0) return '0;
            gap = pk - eq;
            num = gap;
            num = num << FRAC_W;
            den = pk;
            quo = num / den;
            return (quo > 128'hFFFF_FFFF) ? '1 : quo[DD_BITS-1:0];
        endfunction

        function void note_sample(bit has_time, logic [TIME_W-1:0] stamp,
                                  logic signed [EQ_W-1:0] eq);
            t_dd_result         r;
            logic [DD_BITS-1:0] dd;
            r = '0;
            dd = '0;
            if (!has_time) begin
                r.status = ST_NO_TIME;
            end else if (have_time && stamp < prev_time) begin
                r.status = ST_BACKWARD;
            end else begin
                r.status = ST_OK;
                prev_time = stamp;
                have_time = 1;
                if (!have_peak || eq >= peak_eq) begin
                    if (in_episode) begin
                        r.episode_closed = 1'b1;
                        r.episode_peak_time = ep_peak_at;
                        r.episode_trough_time = ep_trough_at;
                        r.episode_depth = ep_depth_dd;
                        in_episode = 0;
                    end
                    peak_eq = eq;
                    peak_at = stamp;
                    have_peak = 1;
                    run_len = '0;
                end else begin
                    dd = fraction_below(peak_eq, eq);
                    if (run_len != '1) run_len = run_len + 1'b1;
                    if (run_len > longest_len) longest_len = run_len;
                    if (!in_episode) begin
                        in_episode = 1;
                        ep_peak_at = peak_at;
                        ep_trough_at = stamp;
                        ep_trough_eq = eq;
                        ep_depth_dd = dd;
                    end else if (eq < ep_trough_eq) begin
                        ep_trough_at = stamp;
                        ep_trough_eq = eq;
                        ep_depth_dd = dd;
                    end
                    if (dd > worst_dd) begin
                        worst_dd = dd;
                        worst_peak_at = peak_at;
                        worst_trough_at = stamp;
                    end
                end
            end
            r.drawdown = dd;
            r.peak_level = peak_eq;
            r.underwater_count = run_len;
            r.max_drawdown = worst_dd;
            r.max_peak_time = worst_peak_at;
            r.max_trough_time = worst_trough_at;
            r.longest_underwater = longest_len;
            pending_results.insert(pending_results.size(), r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
            mismatches++;
        endtask

        task compare_field(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_result(t_dd_result got);
            t_dd_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, drawdown", got.drawdown, '0);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("drawdown", got.drawdown, want.drawdown);
            compare_field("peak_level", got.peak_level, want.peak_level);
            compare_field("underwater_count", got.underwater_count, want.underwater_count);
            compare_field("max_drawdown", got.max_drawdown, want.max_drawdown);
            compare_field("max_peak_time", got.max_peak_time, want.max_peak_time);
            compare_field("max_trough_time", got.max_trough_time, want.max_trough_time);
            compare_field("longest_underwater", got.longest_underwater,
                          want.longest_underwater);
            compare_field("episode_closed", got.episode_closed, want.episode_closed);
            compare_field("episode_peak_time", got.episode_peak_time,
                          want.episode_peak_time);
            compare_field("episode_trough_time", got.episode_trough_time,
                          want.episode_trough_time);
            compare_field("episode_depth", got.episode_depth, want.episode_depth);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    dd_in_if  sample_if ();
    dd_out_if result_if ();

    drawdown_tracker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_if),
        .o_out   (result_if)
    );

    drawdown_scoreboard sb = new();

    int     tx_idle_pct;
    int     rx_idle_pct;
    bit     hold_req;
    longint level;
    longint walk_scale;
    int     seg_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off on request.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    result_if.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_dd_result got;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.status = result_if.status;
            got.drawdown = result_if.drawdown;
            got.peak_level = result_if.peak_level;
            got.underwater_count = result_if.underwater_count;
            got.max_drawdown = result_if.max_drawdown;
            got.max_peak_time = result_if.max_peak_time;
            got.max_trough_time = result_if.max_trough_time;
            got.longest_underwater = result_if.longest_underwater;
            got.episode_closed = result_if.episode_closed;
            got.episode_peak_time = result_if.episode_peak_time;
            got.episode_trough_time = result_if.episode_trough_time;
            got.episode_depth = result_if.episode_depth;
            sb.check_result(got);
        end
    end

    function automatic logic [TIME_W-1:0] rand_stamp();
        logic [63:0] u;
        u = {$urandom, $urandom};
        return u[TIME_W-1:0];
    endfunction

    function automatic logic [EQ_W-1:0] rand_equity();
        logic [63:0] u;
        u = {$urandom, $urandom};
        return u[EQ_W-1:0];
    endfunction

    // Mostly small forward steps, some repeats of the last time, a few big jumps.
    function automatic logic [TIME_W-1:0] next_stamp();
        logic [TIME_W-1:0] step;
        logic [TIME_W:0]   sum;
        case ($urandom_range(19))
            0, 1: step = '0;
            2: begin
                step = $urandom;
                step = step << $urandom_range(0, 20);
            end
            default: step = $urandom_range(1, 50);
        endcase
        sum = sb.prev_time + step;
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    // Starts at a falling edge and returns at the falling edge after acceptance.
    task automatic send_sample(input bit has_time, input logic [TIME_W-1:0] stamp,
                               input logic [EQ_W-1:0] eq);
        while ($urandom_range(99) < tx_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.time_present <= has_time;
        sample_if.event_time <= stamp;
        sample_if.equity <= eq;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        sb.note_sample(has_time, stamp, eq);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_sample();
        int                     pick;
        logic [63:0]            u;
        longint                 step;
        logic signed [EQ_W-1:0] eq;
        pick = $urandom_range(99);
        if (pick < 5 || (pick < 10 && sb.prev_time == 0)) begin
            send_sample(1'b0, rand_stamp(), rand_equity());
        end else if (pick < 10) begin
            send_sample(1'b1, rand_stamp() % sb.prev_time, rand_equity());
        end else begin
            // A segment is a random walk that mostly starts at or just below
            // the running peak, so that peaks and episodes keep coming.
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                walk_scale = 64'sd1 <<< $urandom_range(0, 40);
                case ($urandom_range(7))
                    0: begin
                        eq = rand_equity();
                        level = eq;
                    end
                    1: level = longint'($urandom_range(0, 2000)) - 1000;
                    default: begin
                        level = sb.peak_eq;
                        level -= walk_scale * $urandom_range(0, 3);
                    end
                endcase
            end
            seg_left--;
            if (pick < 18) begin
                eq = rand_equity();
            end else begin
                u = {$urandom, $urandom};
                step = u % (2 * walk_scale + 1);
                level = level + step - walk_scale;
                if (level > EQ_HI) level = EQ_HI;
                if (level < EQ_LO) level = EQ_LO;
                eq = level[EQ_W-1:0];
            end
            send_sample(1'b1, next_stamp(), eq);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) random_sample();
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.time_present = 1'b0;
        sample_if.event_time = '0;
        sample_if.equity = '0;
        tx_idle_pct = 18;
        rx_idle_pct = 47;
        hold_req = 1'b0;
        level = 0;
        walk_scale = 1;
        seg_left = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Missing time before anything is known, then a first sample at the
        // lowest equity and a repeated timestamp that raises the peak.
        send_sample(1'b0, rand_stamp(), rand_equity());
        send_sample(1'b1, 62'd0, EQ_BOTTOM);
        send_sample(1'b1, 62'd0, -48'sd5);
        // Underwater below a negative peak: no drawdown, trough still moves.
        send_sample(1'b1, 62'd1, -48'sd10);
        send_sample(1'b1, 62'd2, -48'sd10);
        send_sample(1'b1, 62'd3, -48'sd20);
        send_sample(1'b1, 62'd3, 48'sd0);
        send_sample(1'b1, 62'd4, -48'sd7);
        // Peak of one and the lowest equity saturate the drawdown.
        send_sample(1'b1, 62'd5, 48'sd1);
        send_sample(1'b1, 62'd6, EQ_BOTTOM);
        send_sample(1'b1, 62'd7, 48'sd0);
        send_sample(1'b1, 62'd7, 48'sd1);
        // Equal worst drawdown and equal trough must not replace the old ones.
        send_sample(1'b1, 62'd8, 48'sd1000);
        send_sample(1'b1, 62'd9, 48'sd500);
        send_sample(1'b1, 62'd10, EQ_BOTTOM);
        send_sample(1'b1, 62'd11, EQ_BOTTOM);
        send_sample(1'b1, 62'd9, 48'sd0);
        send_sample(1'b0, '1, '1);
        send_sample(1'b1, 62'd12, 48'sd1000);
        wait_drained();

        run_phase(18, 47, 650);
        run_phase(47, 18, 650);
        // The result side stalls for a long stretch while requests keep coming.
        hold_req = 1'b1;
        run_phase(0, 0, 650);

        // The largest time and equity come last, since neither can be undone.
        send_sample(1'b1, '1, EQ_TOP);
        send_sample(1'b1, '1, EQ_BOTTOM);
        send_sample(1'b1, {{(TIME_W-1){1'b1}}, 1'b0}, 48'sd0);
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
